### design/hte_pkg.sv
// Shared types, op codes and constants of the Huffman table encoder and bit packer.
package hte_pkg;

   // Op codes carried in req_tuser
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam int DEF_SYMBOLS      = 256;
   localparam int DEF_MAX_CODE_LEN = 16;
   localparam int CODE_W           = 16;
   localparam int LEN_W            = 5;
   localparam int SYM_W            = 8;
   localparam int PEND_W           = 7;

   // One code table entry
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   // Table write request (address travels beside it)
   typedef struct packed {
      logic      en;
      entry_type entry;
   } table_wr_type;

   // Item waiting in the stage after the table read
   typedef struct packed {
      logic valid;
      logic flush;
      logic hit;
   } stage_type;

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic [3:0] pad_bits;
      logic       is_final;
      logic       last;
   } result_type;

endpackage

### design/hte_code_table.sv
// Code table memory with per-entry valid bits and a registered read port.
module hte_code_table #(
   parameter int SYMBOLS = hte_pkg::DEF_SYMBOLS,
   parameter int IDX_W   = $clog2(SYMBOLS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hte_pkg::table_wr_type wr,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic                 rd_en,
   input  logic [IDX_W-1:0]     rd_addr,
   output hte_pkg::entry_type   rd_data
);

   hte_pkg::entry_type mem [SYMBOLS];
   hte_pkg::entry_type rd_data_ff;
   logic [SYMBOLS-1:0] valid_ff;
   logic [SYMBOLS-1:0] valid_in;
   logic               rd_valid_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Mark written entries; an unwritten entry reads as length zero
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### design/hte_packer.sv
// Bit accumulator, byte extraction and result queue driving the rsp channel.
module hte_packer (
   input  logic               clock,
   input  logic               reset,
   input  hte_pkg::stage_type stage,
   input  hte_pkg::entry_type entry,
   output logic               take,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // out_byte[7:0], pad_bits[11:8], zero[15:12]
   output logic [0:0]         rsp_tuser,   // is_final[0]
   output logic               rsp_tlast
);

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);
   localparam int ACC_W   = hte_pkg::PEND_W + hte_pkg::CODE_W;

   logic [hte_pkg::PEND_W-1:0] acc_ff, acc_in;
   logic [2:0]                 pend_ff, pend_in;
   hte_pkg::result_type        q_ff [Q_DEPTH];
   logic [Q_AW-1:0]            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0]            count_ff, count_in;

   logic                pop;
   logic                room;
   logic [ACC_W-1:0]    acc_wide;
   logic [4:0]          cnt;
   logic [15:0]         done_bits;
   logic [15:0]         flush_bits;
   logic [3:0]          pad;
   logic [1:0]          n_push;
   hte_pkg::result_type r0, r1;
   hte_pkg::result_type head;

   assign pop  = rsp_tvalid && rsp_tready;
   assign room = (count_ff <= Q_CW'(Q_DEPTH - 2)) ||
                 ((count_ff == Q_CW'(Q_DEPTH - 1)) && pop);
   assign take = stage.valid && room;

   // Append code word and split off completed bytes
   assign acc_wide   = (ACC_W'(acc_ff) << entry.len) | ACC_W'(entry.code);
   assign cnt        = 5'(pend_ff) + entry.len;
   assign done_bits  = 16'(acc_wide >> cnt[2:0]);
   assign pad        = 4'd8 - 4'(pend_ff);
   assign flush_bits = 16'(acc_ff) << pad;

   // Build results and next accumulator state
   always_comb begin
      acc_in  = acc_ff;
      pend_in = pend_ff;
      n_push  = 2'd0;
      r0      = '0;
      r1      = '0;
      if (take) begin
         if (stage.flush) begin
            r0.out_byte = flush_bits[7:0];
            r0.pad_bits = pad;
            r0.is_final = 1'b1;
            r0.last     = 1'b1;
            n_push      = 2'd1;
            acc_in      = '0;
            pend_in     = '0;
         end else if (stage.hit) begin
            acc_in  = acc_wide[hte_pkg::PEND_W-1:0] &
                      ((hte_pkg::PEND_W'(1) << cnt[2:0]) - hte_pkg::PEND_W'(1));
            pend_in = cnt[2:0];
            n_push  = cnt[4:3];
            if (cnt[4]) begin
               r0.out_byte = done_bits[15:8];
               r1.out_byte = done_bits[7:0];
               r1.last     = 1'b1;
            end else begin
               r0.out_byte = done_bits[7:0];
               r0.last     = 1'b1;
            end
         end
      end
   end

   // Advance queue pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_AW'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + Q_CW'(n_push) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pend_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         acc_ff    <= acc_in;
         pend_ff   <= pend_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store result beats
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         q_ff[wr_ptr_ff] <= r0;
      end
      if (n_push == 2'd2) begin
         q_ff[wr_ptr_ff + Q_AW'(1)] <= r1;
      end
   end

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {4'b0, head.pad_bits, head.out_byte};
   assign rsp_tuser  = head.is_final;
   assign rsp_tlast  = head.last;

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CW'(Q_DEPTH))
      else $error("result queue overfilled");

   a_flush_clears : assert property (@(posedge clock) disable iff (reset)
      take && stage.flush |=> pend_ff == '0 && acc_ff == '0)
      else $error("flush left pending bits");

   a_pad_only_final : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && head.pad_bits != 4'd0 |-> head.is_final && head.last)
      else $error("pad count on a non-final beat");

   a_take_has_room : assert property (@(posedge clock) disable iff (reset)
      take |=> count_ff <= Q_CW'(Q_DEPTH))
      else $error("item taken without queue room");

endmodule

### design/huffman_table_encoder_packer_core.sv
// Top level of the Huffman table encoder and bit packer.
// Accepts one req beat per cycle unless a held item waits for queue room: op in req_tuser,
// symbol/code/length in req_tdata. A load writes the code table in the cycle it is accepted;
// an encode reads the table's registered port and waits in the stage register until the
// packer takes it and appends the code to a 7-bit pending accumulator; a flush pads to a byte
// and emits the final beat with its pad count. Each rsp beat is one byte, so an encode that
// completes two bytes takes two rsp beats; a four-entry result queue absorbs this, and req
// stays ready while the queue has room for two more beats. Table entries reset to length zero
// through per-entry valid bits, so there is no clearing pass after reset.
module huffman_table_encoder_packer_core #(
   parameter int SYMBOLS      = hte_pkg::DEF_SYMBOLS,
   parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // symbol[7:0], code_bits[23:8], code_len[28:24], zero[31:29]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], pad_bits[11:8], zero[15:12]
   output logic [0:0]  rsp_tuser,   // is_final[0]
   output logic        rsp_tlast
);

   localparam int IDX_W   = $clog2(SYMBOLS);
   localparam int LEN_CAP = (MAX_CODE_LEN < hte_pkg::CODE_W) ? MAX_CODE_LEN : hte_pkg::CODE_W;

   logic [hte_pkg::SYM_W-1:0]  symbol;
   logic [hte_pkg::CODE_W-1:0] code_bits;
   logic [hte_pkg::LEN_W-1:0]  code_len;
   logic [hte_pkg::LEN_W-1:0]  len_sat;
   logic [hte_pkg::CODE_W:0]   code_mask;
   logic                       accept;
   logic                       in_range;
   logic                       take;
   hte_pkg::table_wr_type      wr;
   hte_pkg::entry_type         rd_data;
   hte_pkg::stage_type         stage_ff, stage_in;

   assign symbol    = req_tdata[7:0];
   assign code_bits = req_tdata[23:8];
   assign code_len  = req_tdata[28:24];

   assign req_tready = !stage_ff.valid || take;
   assign accept     = req_tvalid && req_tready;
   assign in_range   = ({1'b0, symbol} < 9'(SYMBOLS));

   // Saturate length and drop code bits above it
   assign len_sat   = (code_len > hte_pkg::LEN_W'(LEN_CAP)) ? hte_pkg::LEN_W'(LEN_CAP) : code_len;
   assign code_mask = ((hte_pkg::CODE_W+1)'(1) << len_sat) - (hte_pkg::CODE_W+1)'(1);

   always_comb begin
      wr.en         = accept && (req_tuser == hte_pkg::OP_LOAD) && in_range;
      wr.entry.len  = len_sat;
      wr.entry.code = code_bits & code_mask[hte_pkg::CODE_W-1:0];
   end

   // Hold the encode or flush item after the table read until the packer takes it
   always_comb begin
      stage_in = stage_ff;
      if (take) begin
         stage_in.valid = 1'b0;
      end
      if (accept && ((req_tuser == hte_pkg::OP_ENCODE) || (req_tuser == hte_pkg::OP_FLUSH))) begin
         stage_in.valid = 1'b1;
         stage_in.flush = (req_tuser == hte_pkg::OP_FLUSH);
         stage_in.hit   = in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   hte_code_table #(
      .SYMBOLS (SYMBOLS),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_addr (symbol[IDX_W-1:0]),
      .rd_en   (accept && (req_tuser == hte_pkg::OP_ENCODE)),
      .rd_addr (symbol[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   hte_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage_ff),
      .entry      (rd_data),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/huffman_table_encoder_packer_core_tb.sv
// Self-checking testbench for the Huffman table encoder and bit packer core.
`timescale 1ns / 100ps

module huffman_table_encoder_packer_core_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LEN_CAP      = (hte_pkg::DEF_MAX_CODE_LEN < hte_pkg::CODE_W) ?
                                 hte_pkg::DEF_MAX_CODE_LEN : hte_pkg::CODE_W;
   localparam int TOTAL_ITEMS  = 1950;
   localparam int HOLD_AT      = 600;
   localparam int DRAIN_AT     = 1200;
   localparam int TAIL_AT      = 1650;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   // One row of stimulus; fixed rows carry their expected beats typed in
   typedef struct packed {
      logic [1:0]                 op;
      logic [hte_pkg::SYM_W-1:0]  sym;
      logic [hte_pkg::CODE_W-1:0] bits;
      logic [hte_pkg::LEN_W-1:0]  len;
      logic                       fixed;
      logic [1:0]                 nexp;
      hte_pkg::result_type        e0;
      hte_pkg::result_type        e1;
   } req_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // symbol[7:0], code_bits[23:8], code_len[28:24], zero[31:29]
   logic [1:0]  req_tuser;   // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // out_byte[7:0], pad_bits[11:8], zero[15:12]
   logic [0:0]  rsp_tuser;   // is_final[0]
   logic        rsp_tlast;

   // Packer state mirror
   logic [hte_pkg::CODE_W-1:0] code_word_tab [0:255];
   logic [hte_pkg::LEN_W-1:0]  code_len_tab [0:255];
   logic [31:0]                acc_bits;
   int                         acc_count;
   hte_pkg::result_type        model_beats [0:1];

   hte_pkg::result_type expected_bytes [$];
   req_row_type         directed [$];
   int                  mismatch_count;
   int                  items_sent;
   int                  cycle_count;
   logic                tail_phase;
   logic                hold_rsp;

   huffman_table_encoder_packer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one item to the packer mirror; fill model_beats and return their count
   function automatic int pack_model(input logic [1:0] op,
                                     input logic [hte_pkg::SYM_W-1:0] sym,
                                     input logic [hte_pkg::CODE_W-1:0] bits,
                                     input logic [hte_pkg::LEN_W-1:0] len);
      int          n;
      int          cnt;
      logic [31:0] acc;
      logic [4:0]  l;
      logic [3:0]  pad;
      n = 0;
      case (op)
         hte_pkg::OP_LOAD: begin
            l = (len > LEN_CAP) ? 5'(LEN_CAP) : len;
            code_len_tab[sym]  = l;
            code_word_tab[sym] = 16'(bits & ((32'd1 << l) - 32'd1));
         end
         hte_pkg::OP_ENCODE: begin
            if (code_len_tab[sym] != 0) begin
               acc = (acc_bits << code_len_tab[sym]) | 32'(code_word_tab[sym]);
               cnt = acc_count + code_len_tab[sym];
               // emit every complete byte, oldest bits first
               while (cnt >= 8) begin
                  cnt = cnt - 8;
                  model_beats[n] = '{acc[cnt +: 8], 4'd0, 1'b0, 1'b0};
                  n++;
               end
               if (n > 0) model_beats[n-1].last = 1'b1;
               acc_bits  = acc & ((32'd1 << cnt) - 32'd1);
               acc_count = cnt;
            end
         end
         hte_pkg::OP_FLUSH: begin
            pad = 4'(8 - acc_count);
            acc = acc_bits << pad;
            model_beats[0] = '{acc[7:0], pad, 1'b1, 1'b1};
            n = 1;
            acc_bits  = '0;
            acc_count = 0;
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic hte_pkg::result_type rsp_beat(input logic [7:0] ob,
                                                    input logic [3:0] pad,
                                                    input logic fin, input logic lst);
      return '{ob, pad, fin, lst};
   endfunction

   function automatic req_row_type req_row(input logic [1:0] op, input logic [7:0] sym,
                                           input logic [15:0] bits, input logic [4:0] len);
      return '{op, sym, bits, len, 1'b0, 2'd0, '0, '0};
   endfunction

   function automatic req_row_type req_row_fixed(input logic [1:0] op, input logic [7:0] sym,
                                                 input logic [15:0] bits,
                                                 input logic [4:0] len,
                                                 input logic [1:0] nexp,
                                                 input hte_pkg::result_type e0,
                                                 input hte_pkg::result_type e1);
      return '{op, sym, bits, len, 1'b1, nexp, e0, e1};
   endfunction

   // Mostly legal lengths, some absent, some overlong
   function automatic logic [4:0] rand_code_len();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 5'd0;
      if (pick == 1) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(1, 16));
   endfunction

   // Append one expected beat to the scoreboard
   task automatic queue_beat(input hte_pkg::result_type b);
      expected_bytes.insert(expected_bytes.size(), b);
   endtask

   // Append one directed row
   task automatic add_row(input req_row_type r);
      directed.insert(directed.size(), r);
   endtask

   // Offer one beat, wait for acceptance, then queue its expected bytes
   task automatic send_req(input req_row_type r);
      int gap;
      int n;
      // pause the sender until the block has drained
      if (items_sent == DRAIN_AT) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (expected_bytes.size() != 0) @(posedge clock);
      end
      gap = 0;
      if (!tail_phase && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.len, r.bits, r.sym};
      req_tuser  <= r.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = pack_model(r.op, r.sym, r.bits, r.len);
      if (r.fixed) begin
         if (r.nexp > 0) queue_beat(r.e0);
         if (r.nexp > 1) queue_beat(r.e1);
      end else begin
         for (int i = 0; i < n; i++) queue_beat(model_beats[i]);
      end
      items_sent++;
      if (items_sent == HOLD_AT) hold_rsp = 1'b1;
      if (items_sent == TAIL_AT) tail_phase = 1'b1;
   endtask

   task automatic note_mismatch(input string what, input hte_pkg::result_type want,
                                input hte_pkg::result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %0s: expected byte %02h pad %0d final %0d last %0d,",
                  $time, what, want.out_byte, want.pad_bits, want.is_final, want.last,
                  " got byte %02h pad %0d final %0d last %0d",
                  got.out_byte, got.pad_bits, got.is_final, got.last);
   endtask

   // Check each accepted rsp beat against the oldest expected byte
   always @(posedge clock) begin : rsp_check
      hte_pkg::result_type got;
      hte_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tdata[11:8], rsp_tuser[0], rsp_tlast};
         if (expected_bytes.size() == 0) begin
            note_mismatch("unexpected beat", '0, got);
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) note_mismatch("wrong beat", want, got);
         end
      end
   end

   // Stall the receiver in random bursts, once for a long stretch
   initial begin : rsp_stall
      int held;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0]          pool [$];
      logic [7:0]          sym;
      int                  nload;
      int                  nrun;
      int                  pick;
      hte_pkg::result_type none;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = hte_pkg::OP_LOAD;
      tail_phase     = 1'b0;
      hold_rsp       = 1'b0;
      mismatch_count = 0;
      items_sent     = 0;
      cycle_count    = 0;
      acc_bits       = '0;
      acc_count      = 0;
      none           = '0;
      for (int i = 0; i < 256; i++) begin
         code_word_tab[i] = '0;
         code_len_tab[i]  = '0;
      end

      // Directed rows: reset state, extremes, ignored op, saturation, stray bits
      add_row(req_row_fixed(hte_pkg::OP_FLUSH, 8'h00, 16'h0000, 5'd0, 2'd1,
                            rsp_beat(8'h00, 4'd8, 1'b1, 1'b1), none));
      add_row(req_row_fixed(hte_pkg::OP_ENCODE, 8'h05, 16'h0000, 5'd0, 2'd0, none, none));
      add_row(req_row_fixed(OP_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 2'd0, none, none));
      add_row(req_row_fixed(hte_pkg::OP_LOAD, 8'hFF, 16'hFFFF, 5'd16, 2'd0, none, none));
      add_row(req_row_fixed(hte_pkg::OP_ENCODE, 8'hFF, 16'h0000, 5'd0, 2'd2,
                            rsp_beat(8'hFF, 4'd0, 1'b0, 1'b0),
                            rsp_beat(8'hFF, 4'd0, 1'b0, 1'b1)));
      add_row(req_row_fixed(hte_pkg::OP_FLUSH, 8'h00, 16'h0000, 5'd0, 2'd1,
                            rsp_beat(8'h00, 4'd8, 1'b1, 1'b1), none));
      add_row(req_row_fixed(hte_pkg::OP_LOAD, 8'h00, 16'hFFFF, 5'd31, 2'd0, none, none));
      add_row(req_row_fixed(hte_pkg::OP_ENCODE, 8'h00, 16'hFFFF, 5'd31, 2'd2,
                            rsp_beat(8'hFF, 4'd0, 1'b0, 1'b0),
                            rsp_beat(8'hFF, 4'd0, 1'b0, 1'b1)));
      add_row(req_row_fixed(hte_pkg::OP_LOAD, 8'h01, 16'hFFFF, 5'd1, 2'd0, none, none));
      add_row(req_row_fixed(hte_pkg::OP_ENCODE, 8'h01, 16'h0000, 5'd0, 2'd0, none, none));
      add_row(req_row_fixed(hte_pkg::OP_FLUSH, 8'hFF, 16'hFFFF, 5'd31, 2'd1,
                            rsp_beat(8'h80, 4'd7, 1'b1, 1'b1), none));
      add_row(req_row(hte_pkg::OP_LOAD, 8'h02, 16'h0005, 5'd3));
      add_row(req_row(hte_pkg::OP_LOAD, 8'h03, 16'hABCD, 5'd7));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'h02, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'h03, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'hFF, 16'h0000, 5'd0));
      add_row(req_row(OP_UNUSED, 8'h5A, 16'h1234, 5'd9));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'h01, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_LOAD, 8'h01, 16'hFFFF, 5'd0));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'h01, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_LOAD, 8'h80, 16'h0000, 5'd16));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'h80, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_ENCODE, 8'h03, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_FLUSH, 8'h00, 16'h0000, 5'd0));
      add_row(req_row(hte_pkg::OP_LOAD, 8'h7F, 16'h1234, 5'd17));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_req(directed[i]);

      // Random segments: reload a few entries, then mostly encode them
      while (items_sent < TOTAL_ITEMS) begin
         pool.delete();
         nload = $urandom_range(4, 24);
         repeat (nload) begin
            sym = 8'($urandom_range(0, 255));
            pool.insert(pool.size(), sym);
            send_req(req_row(hte_pkg::OP_LOAD, sym, 16'($urandom()), rand_code_len()));
         end
         nrun = $urandom_range(20, 80);
         repeat (nrun) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               if ($urandom_range(0, 9) != 0) sym = pool[$urandom_range(0, pool.size() - 1)];
               else sym = 8'($urandom_range(0, 255));
               send_req(req_row(hte_pkg::OP_ENCODE, sym, 16'($urandom()), 5'($urandom())));
            end else if (pick < 85) begin
               send_req(req_row(hte_pkg::OP_FLUSH, 8'($urandom()), 16'($urandom()),
                                5'($urandom())));
            end else if (pick < 95) begin
               send_req(req_row(hte_pkg::OP_LOAD, 8'($urandom()), 16'($urandom()),
                                rand_code_len()));
            end else begin
               send_req(req_row(OP_UNUSED, 8'($urandom()), 16'($urandom()),
                                5'($urandom())));
            end
         end
      end

      // Drain and let the pipeline settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
design/hte_pkg.sv
design/hte_code_table.sv
design/hte_packer.sv
design/huffman_table_encoder_packer_core.sv
dv/huffman_table_encoder_packer_core_tb.sv
